// ===== sv/pst_pkg.sv =====
// Package for the patience stack-top table.
// Holds sizes, operation codes, sequencer states and the result record.
// No dependencies.
package pst_pkg;

  localparam int MaxStacks = 1024;
  localparam int ValueBits = 32;
  localparam int IdxBits   = $clog2(MaxStacks);
  localparam int CntBits   = $clog2(MaxStacks + 1);

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SRCH,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [IdxBits-1:0]   position;
    logic [CntBits-1:0]   stack_count;
    logic                 opened_new;
    logic [ValueBits-1:0] top_value;
    logic                 overflow;
  } result_t;

endpackage

// ===== sv/pst_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Used for the stack-top store; no dependencies.
module pst_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/patience_stack_tops.sv =====
// Top level of the patience-sorting stack-top table.
// Depends on pst_pkg and on pst_ram for the store of tops.
//
//   channel   | handshake          | fields
//   ----------+--------------------+------------------------------------------
//   command   | start_i / busy_o   | op_i, value_i, index_i
//   result    | done_o (strobe)    | position_o, stack_count_o, opened_new_o,
//             |                    | top_value_o, overflow_o
//
// A command transfers when start_i is high and busy_o is low; its result
// shows for one cycle with done_o. For clear, no-op, an out-of-range read and a
// place into an empty table it shows in the cycle after the transfer. A read
// passes through ST_READ and an appending place through ST_LAST first. A replacing
// place passes ST_LAST and then ST_SRCH for each binary-search step, at most
// ceil(log2(count)) steps; the single RAM port is read once per step.
// Reset clears the count and the sequencer; the tops need no clearing.
// The receiver cannot stall; busy_o is low again in the cycle done_o shows.
module patience_stack_tops
  import pst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           op_i,
  input  logic [ValueBits-1:0] value_i,
  input  logic [IdxBits-1:0]   index_i,
  output logic                 done_o,
  output logic [IdxBits-1:0]   position_o,
  output logic [CntBits-1:0]   stack_count_o,
  output logic                 opened_new_o,
  output logic [ValueBits-1:0] top_value_o,
  output logic                 overflow_o
);

  state_e state_q, state_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic [ValueBits-1:0] value_q, value_d;
  logic [IdxBits-1:0]   idx_q, idx_d;
  logic [IdxBits-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  logic                 mem_we;
  logic [IdxBits-1:0]   mem_addr;
  logic [ValueBits-1:0] mem_wdata;
  logic [ValueBits-1:0] mem_rdata;

  logic                 accept;
  logic                 full;
  logic                 go_new;
  logic                 more;
  logic [IdxBits-1:0]   lo_n, hi_n, mid_n;
  logic [CntBits-1:0]   count_inc;
  logic [IdxBits-1:0]   count_last;

  pst_ram #(
    .Width(ValueBits),
    .Depth(MaxStacks)
  ) u_tops (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign accept     = start_i && (state_q == ST_IDLE);
  assign full       = (count_q == CntBits'(MaxStacks));
  assign go_new     = (value_q >= mem_rdata);
  assign count_inc  = count_q + CntBits'(1);
  assign count_last = IdxBits'(count_q - CntBits'(1));

  // One binary-search step. Entering from ST_LAST the window is the whole
  // table; in ST_SRCH the read data is the top at mid_q.
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == ST_LAST) begin
      lo_n = '0;
      hi_n = count_last;
    end else if (mem_rdata > value_q) begin
      hi_n = mid_q;
    end else begin
      lo_n = mid_q + IdxBits'(1);
    end
    more  = (lo_n < hi_n);
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_PLACE: if (count_q != '0) state_d = ST_LAST;
            OP_READ:  if ({1'b0, index_i} < count_q) state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LAST: begin
        if (!go_new && more) state_d = ST_SRCH;
        else state_d = ST_IDLE;
      end
      ST_SRCH: begin
        if (!more) state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    count_d   = count_q;
    value_d   = value_q;
    idx_d     = idx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_addr  = mid_q;
    mem_wdata = value_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = value_i;
          idx_d   = index_i;
          case (op_e'(op_i))
            OP_PLACE: begin
              if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_addr  = '0;
                mem_wdata = value_i;
                count_d   = CntBits'(1);
                done_d    = 1'b1;
                res_d     = '{'0, CntBits'(1), 1'b1, value_i, 1'b0};
              end else begin
                mem_addr = count_last;
              end
            end
            OP_READ: begin
              if ({1'b0, index_i} < count_q) begin
                mem_addr = index_i;
              end else begin
                done_d = 1'b1;
                res_d  = '{index_i, count_q, 1'b0, '0, 1'b0};
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
              res_d   = '{'0, '0, 1'b0, '0, 1'b0};
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{'0, count_q, 1'b0, '0, 1'b0};
            end
          endcase
        end
      end
      ST_LAST, ST_SRCH: begin
        if (state_q == ST_LAST && go_new) begin
          done_d = 1'b1;
          if (full) begin
            res_d = '{IdxBits'(MaxStacks - 1), count_q, 1'b0, value_q, 1'b1};
          end else begin
            mem_we   = 1'b1;
            mem_addr = IdxBits'(count_q);
            count_d  = count_inc;
            res_d    = '{IdxBits'(count_q), count_inc, 1'b1, value_q, 1'b0};
          end
        end else if (more) begin
          lo_d     = lo_n;
          hi_d     = hi_n;
          mid_d    = mid_n;
          mem_addr = mid_n;
        end else begin
          mem_we   = 1'b1;
          mem_addr = lo_n;
          done_d   = 1'b1;
          res_d    = '{lo_n, count_q, 1'b0, value_q, 1'b0};
        end
      end
      ST_READ: begin
        done_d = 1'b1;
        res_d  = '{idx_q, count_q, 1'b0, mem_rdata, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign position_o    = res_q.position;
  assign stack_count_o = res_q.stack_count;
  assign opened_new_o  = res_q.opened_new;
  assign top_value_o   = res_q.top_value;
  assign overflow_o    = res_q.overflow;

  // The count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxStacks))
    else $error("stack count above table size");

  // The probe address stays inside the search window.
  a_mid_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q <= mid_q) && (mid_q < hi_q))
    else $error("search probe outside window");

  // An accepted command either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("command transfer lost");

  // A new stack is always the last one.
  a_new_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && opened_new_o) |-> ({1'b0, position_o} + CntBits'(1) == stack_count_o))
    else $error("new stack not at the end");

  // Overflow only reports a full table.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |-> (stack_count_o == CntBits'(MaxStacks)) && !opened_new_o)
    else $error("overflow without a full table");

endmodule

// ===== bench/patience_stack_tops_tb.sv =====
// Testbench for patience_stack_tops: drives place, read, clear and no-op commands,
// predicts each result from its own copy of the stack-top table and checks every
// result field. Depends on pst_pkg and the patience_stack_tops RTL.
module patience_stack_tops_tb
  import pst_pkg::*;
();

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 20;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start_i = 1'b0;
  logic [1:0]           op_i    = OP_PLACE;
  logic [ValueBits-1:0] value_i = '0;
  logic [IdxBits-1:0]   index_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [IdxBits-1:0]   position_o;
  logic [CntBits-1:0]   stack_count_o;
  logic                 opened_new_o;
  logic [ValueBits-1:0] top_value_o;
  logic                 overflow_o;

  // Copy of the table as the block should hold it after every accepted command.
  logic [ValueBits-1:0] table_tops [MaxStacks];
  int unsigned          table_count = 0;
  result_t              pending_results [$];
  int unsigned          fail_count   = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          idle_pct     = 7;

  always #10 clk_i = ~clk_i;

  patience_stack_tops i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .done_o        (done_o),
    .position_o    (position_o),
    .stack_count_o (stack_count_o),
    .opened_new_o  (opened_new_o),
    .top_value_o   (top_value_o),
    .overflow_o    (overflow_o)
  );

  function automatic result_t apply_to_table(input op_e op, input logic [ValueBits-1:0] value,
                                             input logic [IdxBits-1:0] index);
    result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    case (op)
      OP_PLACE: begin
        r.top_value = value;
        if (table_count == 0 || value >= table_tops[table_count-1]) begin
          if (table_count >= MaxStacks) begin
            r.overflow = 1'b1;
            r.position = IdxBits'(MaxStacks - 1);
          end else begin
            table_tops[table_count] = value;
            r.position   = IdxBits'(table_count);
            r.opened_new = 1'b1;
            table_count++;
          end
        end else begin
          // Leftmost top strictly greater than the value.
          lo = 0;
          hi = table_count - 1;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (table_tops[mid] > value) hi = mid;
            else lo = mid + 1;
          end
          table_tops[lo] = value;
          r.position = IdxBits'(lo);
        end
      end
      OP_READ: begin
        r.position = index;
        if (index < table_count) r.top_value = table_tops[index];
      end
      OP_CLEAR: table_count = 0;
      default: ;
    endcase
    r.stack_count = CntBits'(table_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ValueBits-1:0] expv,
                             input logic [ValueBits-1:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && !busy_o) || done_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, position %0h top %0h", $time,
                 position_o, top_value_o);
        fail_count++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        check_field("position", ValueBits'(want.position), ValueBits'(position_o));
        check_field("stack_count", ValueBits'(want.stack_count), ValueBits'(stack_count_o));
        check_field("opened_new", ValueBits'(want.opened_new), ValueBits'(opened_new_o));
        check_field("top_value", want.top_value, top_value_o);
        check_field("overflow", ValueBits'(want.overflow), ValueBits'(overflow_o));
      end
    end
  end

  // One command transfer; the expected result is queued at the accepting edge.
  task automatic send_cmd(input op_e op, input logic [ValueBits-1:0] value,
                          input logic [IdxBits-1:0] index);
    result_t exp_res;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= value;
    index_i <= index;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    exp_res = apply_to_table(op, value, index);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueBits-1:0] pick_place_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: return $urandom_range(15);
      default: begin
        if (table_count == 0) return $urandom;
        return table_tops[table_count-1] + $urandom_range(1000);
      end
    endcase
  endfunction

  task automatic test_directed_cases();
    send_cmd(OP_READ, '0, '0);
    send_cmd(OP_READ, '0, '1);
    send_cmd(OP_NOP, '1, '1);
    send_cmd(OP_PLACE, 32'd5, '0);
    send_cmd(OP_PLACE, 32'd5, '0);
    send_cmd(OP_PLACE, 32'd0, '0);
    send_cmd(OP_PLACE, 32'hFFFF_FFFF, '1);
    send_cmd(OP_PLACE, 32'd3, '0);
    send_cmd(OP_PLACE, 32'hFFFF_FFFE, '0);
    send_cmd(OP_READ, '0, 10'd0);
    send_cmd(OP_READ, '0, 10'd2);
    send_cmd(OP_READ, '0, 10'd3);
    send_cmd(OP_READ, '1, 10'd1023);
    send_cmd(OP_NOP, '0, '0);
    send_cmd(OP_CLEAR, '1, '1);
    send_cmd(OP_READ, '0, 10'd0);
    send_cmd(OP_PLACE, 32'h8000_0000, '0);
    send_cmd(OP_PLACE, 32'h7FFF_FFFF, '0);
    send_cmd(OP_PLACE, 32'd1, '0);
    send_cmd(OP_PLACE, 32'hAAAA_AAAA, 10'h2AA);
    send_cmd(OP_PLACE, 32'h5555_5555, 10'h155);
    send_cmd(OP_READ, '0, 10'd1);
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    int unsigned roll;
    logic [IdxBits-1:0] idx;
    for (int i = 0; i < 700; i++) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_cmd(OP_PLACE, pick_place_value(), IdxBits'($urandom));
      end else if (roll < 92) begin
        if (table_count > 0 && $urandom_range(3) != 0) begin
          idx = IdxBits'($urandom_range(table_count - 1));
        end else begin
          idx = IdxBits'($urandom);
        end
        send_cmd(OP_READ, $urandom, idx);
      end else if (roll < 96) begin
        send_cmd(OP_CLEAR, $urandom, IdxBits'($urandom));
      end else begin
        send_cmd(OP_NOP, $urandom, IdxBits'($urandom));
      end
      if ($urandom_range(99) == 0) wait_results_drained();
    end
  endtask

  // Fills all stacks with a back-to-back run, then works on the full table.
  task automatic test_fill_and_overflow();
    logic [ValueBits-1:0] fill_value;
    logic [ValueBits-1:0] last_top;
    int unsigned roll;
    idle_pct = 0;
    send_cmd(OP_CLEAR, '0, '0);
    fill_value = $urandom_range(1 << 20);
    while (table_count < MaxStacks) begin
      send_cmd(OP_PLACE, fill_value, IdxBits'($urandom));
      if ($urandom_range(3) != 0) fill_value = fill_value + $urandom_range(1, 1 << 21);
    end
    idle_pct = 7;
    send_cmd(OP_PLACE, 32'hFFFF_FFFF, '0);
    send_cmd(OP_READ, '0, 10'd1023);
    for (int i = 0; i < 120; i++) begin
      roll = $urandom_range(99);
      last_top = table_tops[table_count-1];
      if (roll < 30) begin
        send_cmd(OP_PLACE, $urandom_range(32'hFFFF_FFFF, last_top), IdxBits'($urandom));
      end else if (roll < 70 && last_top != 0) begin
        send_cmd(OP_PLACE, $urandom_range(last_top - 1), IdxBits'($urandom));
      end else if (roll < 95) begin
        send_cmd(OP_READ, $urandom, IdxBits'($urandom));
      end else begin
        send_cmd(OP_NOP, $urandom, IdxBits'($urandom));
      end
    end
    wait_results_drained();
    send_cmd(OP_READ, '0, 10'd1023);
    send_cmd(OP_CLEAR, '0, '0);
    send_cmd(OP_READ, '0, 10'd0);
  endtask

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_mix();
    test_fill_and_overflow();
    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pst_pkg.sv
sv/pst_ram.sv
sv/patience_stack_tops.sv
bench/patience_stack_tops_tb.sv
